// File: sv/wsfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Shared types and constants for the frame parser and its output stage.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    // Parse phase of the current frame.
    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_EXT0    = 4'd2,
        PH_EXT1    = 4'd3,
        PH_MASK0   = 4'd4,
        PH_MASK1   = 4'd5,
        PH_MASK2   = 4'd6,
        PH_MASK3   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_SKIP    = 4'd9
    } phase_t;

    // Frame status codes reported with the final byte.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LEN     = 3'd1,
        ST_LEN64   = 3'd2,
        ST_NOFIN   = 3'd3,
        ST_NOTTEXT = 3'd4
    } status_t;

    localparam logic [6:0]  LEN7_MASK   = 7'h7F;
    localparam logic [6:0]  LEN_EXT16   = 7'd126;
    localparam logic [6:0]  LEN_EXT64   = 7'd127;
    localparam logic [3:0]  OPCODE_MASK = 4'hF;
    localparam logic [3:0]  OPCODE_TEXT = 4'h1;
    localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

    // One result item as it leaves the parser.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] payload_byte;
        logic       frame_end;
        status_t    status;
    } result_t;

endpackage

// File: sv/wsfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Holds the header state of the frame in flight, updates it once per
// accepted byte and forms the unmasked payload byte and final status.
// ----------------------------------------------------------------------------
module wsfd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                rx_last,
    output logic                result_present,
    output wsfd_pkg::result_t   result
);

    wsfd_pkg::phase_t phase_reg, phase_next, phase_upd;
    logic [7:0]       fin_and_opcode_reg, fin_and_opcode_next, fin_and_opcode_upd;
    logic             is_masked_reg, is_masked_next, is_masked_upd;
    logic [15:0]      declared_length_reg, declared_length_next, declared_length_upd;
    logic [16:0]      payload_count_reg, payload_count_next, payload_count_upd;
    logic [31:0]      mask_key_reg, mask_key_next, mask_key_upd;
    logic [1:0]       mask_index_reg, mask_index_next, mask_index_upd;
    logic             len64_reg, len64_next, len64_upd;
    logic             in_payload;
    logic [6:0]       len7;
    logic [7:0]       key_byte;
    logic             byte_out;

    assign len7       = rx_byte[6:0] & wsfd_pkg::LEN7_MASK;
    assign in_payload = (phase_reg == wsfd_pkg::PH_PAYLOAD) &&
                        (payload_count_reg < {1'b0, declared_length_reg});

    // Key byte for the current payload position, first key byte is the MSB.
    always_comb
    begin
        case (mask_index_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    // Header parse step: the state after this byte, before end-of-frame reset.
    always_comb
    begin
        phase_upd           = phase_reg;
        fin_and_opcode_upd  = fin_and_opcode_reg;
        is_masked_upd       = is_masked_reg;
        declared_length_upd = declared_length_reg;
        payload_count_upd   = payload_count_reg;
        mask_key_upd        = mask_key_reg;
        mask_index_upd      = mask_index_reg;
        len64_upd           = len64_reg;
        case (phase_reg)
            wsfd_pkg::PH_HDR0:
            begin
                fin_and_opcode_upd = rx_byte;
                phase_upd          = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1:
            begin
                is_masked_upd = rx_byte[7];
                if (len7 == wsfd_pkg::LEN_EXT16)
                begin
                    phase_upd = wsfd_pkg::PH_EXT0;
                end
                else if (len7 == wsfd_pkg::LEN_EXT64)
                begin
                    len64_upd = 1'b1;
                    phase_upd = wsfd_pkg::PH_SKIP;
                end
                else
                begin
                    declared_length_upd = {9'd0, len7};
                    phase_upd = rx_byte[7] ? wsfd_pkg::PH_MASK0 : wsfd_pkg::PH_PAYLOAD;
                end
            end
            wsfd_pkg::PH_EXT0:
            begin
                declared_length_upd = {rx_byte, 8'd0};
                phase_upd           = wsfd_pkg::PH_EXT1;
            end
            wsfd_pkg::PH_EXT1:
            begin
                declared_length_upd = {declared_length_reg[15:8], rx_byte};
                phase_upd = is_masked_reg ? wsfd_pkg::PH_MASK0 : wsfd_pkg::PH_PAYLOAD;
            end
            wsfd_pkg::PH_MASK0:
            begin
                mask_key_upd = {mask_key_reg[23:0], rx_byte};
                phase_upd    = wsfd_pkg::PH_MASK1;
            end
            wsfd_pkg::PH_MASK1:
            begin
                mask_key_upd = {mask_key_reg[23:0], rx_byte};
                phase_upd    = wsfd_pkg::PH_MASK2;
            end
            wsfd_pkg::PH_MASK2:
            begin
                mask_key_upd = {mask_key_reg[23:0], rx_byte};
                phase_upd    = wsfd_pkg::PH_MASK3;
            end
            wsfd_pkg::PH_MASK3:
            begin
                mask_key_upd = {mask_key_reg[23:0], rx_byte};
                phase_upd    = wsfd_pkg::PH_PAYLOAD;
            end
            wsfd_pkg::PH_PAYLOAD:
            begin
                if (in_payload)
                begin
                    mask_index_upd = mask_index_reg + 2'd1;
                end
                if (payload_count_reg != wsfd_pkg::COUNT_MAX)
                begin
                    payload_count_upd = payload_count_reg + 17'd1;
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    // Next state: the final byte returns every field to its reset value.
    always_comb
    begin
        if (accept && rx_last)
        begin
            phase_next           = wsfd_pkg::PH_HDR0;
            fin_and_opcode_next  = '0;
            is_masked_next       = 1'b0;
            declared_length_next = '0;
            payload_count_next   = '0;
            mask_key_next        = '0;
            mask_index_next      = '0;
            len64_next           = 1'b0;
        end
        else if (accept)
        begin
            phase_next           = phase_upd;
            fin_and_opcode_next  = fin_and_opcode_upd;
            is_masked_next       = is_masked_upd;
            declared_length_next = declared_length_upd;
            payload_count_next   = payload_count_upd;
            mask_key_next        = mask_key_upd;
            mask_index_next      = mask_index_upd;
            len64_next           = len64_upd;
        end
        else
        begin
            phase_next           = phase_reg;
            fin_and_opcode_next  = fin_and_opcode_reg;
            is_masked_next       = is_masked_reg;
            declared_length_next = declared_length_reg;
            payload_count_next   = payload_count_reg;
            mask_key_next        = mask_key_reg;
            mask_index_next      = mask_index_reg;
            len64_next           = len64_reg;
        end
    end

    // Outputs: payload byte judged on the current frame state, status on the updated one.
    always_comb
    begin
        byte_out              = in_payload;
        result.data_valid     = byte_out;
        result.payload_byte   = byte_out ?
                                (rx_byte ^ (is_masked_reg ? key_byte : 8'd0)) : 8'd0;
        result.frame_end      = rx_last;
        result.status         = wsfd_pkg::ST_OK;
        if (rx_last)
        begin
            if (len64_upd)
            begin
                result.status = wsfd_pkg::ST_LEN64;
            end
            else if ((phase_upd != wsfd_pkg::PH_PAYLOAD) ||
                     (payload_count_upd != {1'b0, declared_length_upd}))
            begin
                result.status = wsfd_pkg::ST_LEN;
            end
            else if (!fin_and_opcode_upd[7])
            begin
                result.status = wsfd_pkg::ST_NOFIN;
            end
            else if ((fin_and_opcode_upd[3:0] & wsfd_pkg::OPCODE_MASK) !=
                     wsfd_pkg::OPCODE_TEXT)
            begin
                result.status = wsfd_pkg::ST_NOTTEXT;
            end
        end
        result_present = accept && (byte_out || rx_last);
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= wsfd_pkg::PH_HDR0;
            fin_and_opcode_reg  <= '0;
            is_masked_reg       <= 1'b0;
            declared_length_reg <= '0;
            payload_count_reg   <= '0;
            mask_key_reg        <= '0;
            mask_index_reg      <= '0;
            len64_reg           <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            fin_and_opcode_reg  <= fin_and_opcode_next;
            is_masked_reg       <= is_masked_next;
            declared_length_reg <= declared_length_next;
            payload_count_reg   <= payload_count_next;
            mask_key_reg        <= mask_key_next;
            mask_index_reg      <= mask_index_next;
            len64_reg           <= len64_next;
        end
    end

endmodule

// File: sv/wsfd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame decoder output stage
// Result register with valid/ready; it takes a new result in the same
// cycle in which the held one is taken.
// ----------------------------------------------------------------------------
module wsfd_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  wsfd_pkg::result_t   result,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                data_valid,
    output logic [7:0]          payload_byte,
    output logic                frame_end,
    output logic [2:0]          status
);

    logic              valid_reg, valid_next;
    wsfd_pkg::result_t data_reg;

    // The register is free when empty or when its request is taken now.
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid    = valid_reg;
    assign data_valid   = data_reg.data_valid;
    assign payload_byte = data_reg.payload_byte;
    assign frame_end    = data_reg.frame_end;
    assign status       = data_reg.status;

endmodule

// File: sv/websocket_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame decoder core
// Parses one RFC 6455 frame per byte stream and gives unmasked payload bytes
// and a final status.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle on the input channel and gives a
// result in the cycle after the byte is accepted: a request for each payload
// byte inside the declared length (unmasked with the 4-byte key when the
// mask bit is set) and one for the byte marked rx_last, which carries
// frame_end and status (0 ok, 1 length mismatch or truncated header,
// 2 64-bit length form, 3 FIN clear, 4 opcode not text). Header bytes and
// surplus bytes give no request. A byte can be accepted in every cycle; the
// single result register sets the latency, and the input stalls only while
// that register holds a request that is not being taken. State returns to
// its reset value after every final byte.
// ----------------------------------------------------------------------------
module websocket_frame_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        data_valid,
    output logic [7:0]  payload_byte,
    output logic        frame_end,
    output logic [2:0]  status
);

    logic              accept;
    logic              result_present;
    logic              can_load;
    wsfd_pkg::result_t result;

    assign in_ready = can_load;
    assign accept   = in_valid && can_load;

    // Header parser and unmask datapath.
    wsfd_parser u_parser
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .rx_last        (rx_last),
        .result_present (result_present),
        .result         (result)
    );

    // Registered result channel.
    wsfd_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (result_present),
        .result       (result),
        .can_load     (can_load),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_valid   (data_valid),
        .payload_byte (payload_byte),
        .frame_end    (frame_end),
        .status       (status)
    );

endmodule
